>>> design/hfm_pkg.sv
// Shared types and constants for the heartbeat fail-safe monitor.
package hfm_pkg;

    // Heartbeat counter bits that are kept and compared
    localparam int HEARTBEAT_BITS = 32;
    localparam int HB_IN_W        = 32;
    localparam int HB_KEEP_W      = (HEARTBEAT_BITS < HB_IN_W) ? HEARTBEAT_BITS : HB_IN_W;

    localparam int S_TDATA_W = 40;  // 1 + 32 + 2 = 35 bits, padded to bytes
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 16;  // 14 bits, padded to bytes

    localparam logic [7:0] FAULT_NONE       = 8'h00;
    localparam logic [7:0] FAULT_HB_LOSS    = 8'hA1;
    localparam logic [7:0] MISS_LIMIT_RESET = 8'd5;
    localparam logic [7:0] MISS_COUNT_MAX   = 8'hFF;

    typedef enum logic [1:0] {
        CMD_POLL  = 2'd0,
        CMD_FORCE = 2'd1,
        CMD_EWI   = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_NORMAL    = 2'd0,
        ST_SPIN_HOME = 2'd1,
        ST_DOCK      = 2'd2,
        ST_STOP      = 2'd3
    } fs_state_t;

    typedef struct packed {
        logic [1:0]         cmd;
        logic               sem_taken;
        logic [HB_IN_W-1:0] heartbeat_value;
        logic [1:0]         forced_state;
    } item_t;

    typedef struct packed {
        logic [1:0] fail_state;
        logic       pwm_kill;
        logic [7:0] fault_id;
        logic       early_wake_enable;
        logic       partner_alive;
        logic       refresh_ok;
    } result_t;

    // Handshake between the input stage and the result stage
    typedef struct packed {
        logic valid;    // input register holds an item
        logic advance;  // item moves into the result register this cycle
    } stage_ctl_t;

endpackage

>>> design/hfm_in_reg.sv
// Input register stage: captures one item per transfer on the slave side.
module hfm_in_reg (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  hfm_pkg::item_t item_in,
    input  logic          advance,
    output logic          valid,
    output hfm_pkg::item_t item_out
);
    import hfm_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // Ready when empty or when the held item leaves this cycle
    assign s_tready   = !valid_reg || advance;
    assign valid_next = (s_tvalid && s_tready) || (valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg <= item_in;
        end
    end

    assign valid    = valid_reg;
    assign item_out = item_reg;

endmodule

>>> design/hfm_core.sv
// Fail-safe state, miss counter and per-item result logic.
module hfm_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wen,
    input  logic [7:0]         cfg_wdata,
    input  hfm_pkg::stage_ctl_t ctl,
    input  hfm_pkg::item_t     item,
    output hfm_pkg::result_t   result
);
    import hfm_pkg::*;

    logic [7:0]           miss_limit_reg;
    logic [7:0]           miss_count_reg, miss_count_next;
    logic [HB_KEEP_W-1:0] last_hb_reg, last_hb_next;
    logic                 dead_latched_reg, dead_latched_next;
    logic [1:0]           state_reg, state_next;
    logic                 shutdown_reg, shutdown_next;
    logic [7:0]           fault_reg, fault_next;
    logic                 ewi_reg, ewi_next;
    logic                 refresh;

    logic [7:0]           miss_inc;
    logic                 dead;
    logic [HB_KEEP_W-1:0] hb;

    assign hb       = item.heartbeat_value[HB_KEEP_W-1:0];
    assign miss_inc = (miss_count_reg == MISS_COUNT_MAX) ? miss_count_reg
                                                         : miss_count_reg + 8'd1;

    // Next state for the item in the input register
    always_comb
    begin
        miss_count_next   = miss_count_reg;
        last_hb_next      = last_hb_reg;
        dead_latched_next = dead_latched_reg;
        state_next        = state_reg;
        shutdown_next     = shutdown_reg;
        fault_next        = fault_reg;
        ewi_next          = ewi_reg;
        refresh           = 1'b0;
        dead              = 1'b0;
        case (item.cmd)
            CMD_POLL:
            begin
                if (item.sem_taken)
                begin
                    miss_count_next = 8'd0;
                end
                else
                begin
                    miss_count_next = miss_inc;
                    dead            = (miss_inc > miss_limit_reg);
                end
                // A moving heartbeat overrides a miss
                if (hb != last_hb_reg)
                begin
                    miss_count_next = 8'd0;
                    dead            = 1'b0;
                end
                last_hb_next = hb;
                if (dead && !dead_latched_reg)
                begin
                    dead_latched_next = 1'b1;
                    shutdown_next     = 1'b1;
                    fault_next        = FAULT_HB_LOSS;
                    state_next        = ST_SPIN_HOME;
                    ewi_next          = 1'b0;
                end
                else if (!dead && dead_latched_reg)
                begin
                    dead_latched_next = 1'b0;
                    shutdown_next     = 1'b0;
                    fault_next        = FAULT_NONE;
                    state_next        = ST_NORMAL;
                    ewi_next          = 1'b1;
                end
            end
            CMD_FORCE:
            begin
                state_next    = item.forced_state;
                shutdown_next = 1'b1;
                fault_next    = {6'd0, item.forced_state};
            end
            CMD_EWI:
            begin
                refresh = (state_reg == ST_NORMAL);
            end
            default:
            begin
                refresh = 1'b0;
            end
        endcase
    end

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            miss_limit_reg <= MISS_LIMIT_RESET;
        end
        else if (cfg_wen)
        begin
            miss_limit_reg <= cfg_wdata;
        end
    end

    // Monitor state, updated as an item moves to the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            miss_count_reg   <= 8'd0;
            last_hb_reg      <= '0;
            dead_latched_reg <= 1'b0;
            state_reg        <= ST_NORMAL;
            shutdown_reg     <= 1'b0;
            fault_reg        <= FAULT_NONE;
            ewi_reg          <= 1'b1;
        end
        else if (ctl.advance)
        begin
            miss_count_reg   <= miss_count_next;
            last_hb_reg      <= last_hb_next;
            dead_latched_reg <= dead_latched_next;
            state_reg        <= state_next;
            shutdown_reg     <= shutdown_next;
            fault_reg        <= fault_next;
            ewi_reg          <= ewi_next;
        end
    end

    // Status after the update
    always_comb
    begin
        result.fail_state        = state_next;
        result.pwm_kill          = shutdown_next;
        result.fault_id          = fault_next;
        result.early_wake_enable = ewi_next;
        result.partner_alive     = (miss_count_next <= miss_limit_reg);
        result.refresh_ok        = refresh;
    end

endmodule

>>> design/hfm_out_reg.sv
// Result register on the master side; refills in the cycle it drains.
module hfm_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              advance,
    input  hfm_pkg::result_t  result_in,
    output logic              m_tvalid,
    input  logic              m_tready,
    output hfm_pkg::result_t  result_out
);
    import hfm_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign advance    = in_valid && (!valid_reg || m_tready);
    assign valid_next = advance || (valid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_in;
        end
    end

    assign m_tvalid   = valid_reg;
    assign result_out = result_reg;

endmodule

>>> design/heartbeat_failsafe_monitor.sv
// Top level of the heartbeat fail-safe monitor.
//
//  channel   | dir | handshake            | payload
//  ----------+-----+----------------------+---------------------------------------------
//  s_*       | in  | s_tvalid / s_tready  | tuser: cmd; tdata: sem_taken, heartbeat, forced
//  m_*       | out | m_tvalid / m_tready  | tdata: state, kill, fault, ewi, alive, refresh
//  cfg_*     | in  | cfg_wen              | cfg_wdata: miss_limit
//
// One item per cycle while m_tready holds. An item waits in the input register,
// then its state update and status are registered in the result register, which
// raises m_tvalid; a stalled sink holds items in the result and input registers.
// The result register drains and refills in the same cycle, so throughput is
// set only by m_tready. Reset clears the monitor state (miss_limit back to 5,
// early-wake enabled) and both valid flags.
module heartbeat_failsafe_monitor (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [hfm_pkg::S_TDATA_W-1:0]   s_tdata,  // [0] sem_taken, [32:1] heartbeat_value,
                                                      // [34:33] forced_state, rest zero
    input  logic [hfm_pkg::S_TUSER_W-1:0]   s_tuser,  // [1:0] cmd
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [hfm_pkg::M_TDATA_W-1:0]   m_tdata,  // [1:0] fail_state, [2] pwm_kill,
                                                      // [10:3] fault_id,
                                                      // [11] early_wake_enable,
                                                      // [12] partner_alive, [13] refresh_ok
    input  logic                            cfg_wen,
    input  logic [7:0]                      cfg_wdata
);
    import hfm_pkg::*;

    item_t      item_in;
    item_t      item_held;
    result_t    result_next;
    result_t    result_out;
    stage_ctl_t ctl;
    logic       in_valid;
    logic       advance;

    // Unpack the slave transfer
    assign item_in.cmd             = s_tuser;
    assign item_in.sem_taken       = s_tdata[0];
    assign item_in.heartbeat_value = s_tdata[HB_IN_W:1];
    assign item_in.forced_state    = s_tdata[HB_IN_W+2:HB_IN_W+1];

    assign ctl.valid   = in_valid;
    assign ctl.advance = advance;

    hfm_in_reg u_in_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .item_in  (item_in),
        .advance  (advance),
        .valid    (in_valid),
        .item_out (item_held)
    );

    hfm_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .ctl       (ctl),
        .item      (item_held),
        .result    (result_next)
    );

    hfm_out_reg u_out_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .advance    (advance),
        .result_in  (result_next),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .result_out (result_out)
    );

    // Pack the master transfer
    assign m_tdata = {2'b00,
                      result_out.refresh_ok,
                      result_out.partner_alive,
                      result_out.early_wake_enable,
                      result_out.fault_id,
                      result_out.pwm_kill,
                      result_out.fail_state};

    // Refresh is only granted in the normal state
    a_refresh_normal: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && result_out.refresh_ok) |-> (result_out.fail_state == ST_NORMAL))
        else $error("refresh_ok with fail-safe state not normal");

    // Early-wake is dropped only together with shutdown
    a_ewi_shutdown: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !result_out.early_wake_enable) |-> result_out.pwm_kill)
        else $error("early-wake disabled without shutdown");

    // Back-pressure only when both stages are full and the sink stalls
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (in_valid && m_tvalid && !m_tready))
        else $error("input stalled without a full pipeline");

    // An item held in the input stage moves on once the sink takes a transfer
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && m_tvalid && m_tready) |-> advance)
        else $error("input item not advanced on output transfer");

endmodule
